[design/arpc_pkg.sv]
package arpc_pkg;

  // Table geometry
  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // Field widths
  localparam int IP_W   = 32;
  localparam int MAC_W  = 48;
  localparam int SLOT_W = 4;
  localparam int REQ_W  = 2;
  localparam int ENT_W  = IP_W + MAC_W;

  // Stream widths (tdata padded to whole bytes)
  localparam int S_DATA_W = ((IP_W + MAC_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((MAC_W + SLOT_W + 7) / 8) * 8;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FLUSH  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [IP_W-1:0]  ip_addr;
    logic [MAC_W-1:0] mac_addr;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [MAC_W-1:0]  mac_out;
    logic [SLOT_W-1:0] slot;
  } res_t;

endpackage

[design/arpc_ram.sv]
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/arpc_engine.sv]
module arpc_engine
  import arpc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req_in,
  output logic idle,
  input  logic res_ready,
  output logic res_valid,
  output res_t res
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_EVAL = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state;
  req_t   req;
  res_t   res_q;

  logic [CNT_W-1:0]   cnt;
  logic               cmp_vld;
  logic [IDX_W-1:0]   cmp_idx;
  logic [ENTRIES-1:0] entry_valid;
  logic [ENTRIES-1:0] entry_written;

  logic               found;
  logic [IDX_W-1:0]   fidx;
  logic [MAC_W-1:0]   fmac;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;

  logic               ram_we;
  logic [IDX_W-1:0]   waddr;
  logic [ENT_W-1:0]   wdata;
  logic [IDX_W-1:0]   raddr;
  logic [ENT_W-1:0]   rdata;
  logic [IP_W-1:0]    eff_ip;
  logic [MAC_W-1:0]   eff_mac;
  logic               issue;
  logic               is_insert;
  logic               match;
  logic [ENTRIES-1:0] wr_mask;

  arpc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Read issue and compare stage
  assign issue     = (state == ST_SCAN) && (cnt < CNT_W'(ENTRIES));
  assign raddr     = cnt[IDX_W-1:0];
  assign is_insert = (req.req_type == REQ_INSERT);

  // Entries never written read as zero
  assign eff_ip  = entry_written[cmp_idx] ? rdata[IP_W-1:0] : '0;
  assign eff_mac = entry_written[cmp_idx] ? rdata[ENT_W-1:IP_W] : '0;

  // Insert matches any entry; lookup only valid ones
  assign match = (is_insert || entry_valid[cmp_idx]) && (eff_ip == req.ip_addr);

  // Write-back target for insert
  always_comb begin
    if (found) begin
      waddr = fidx;
    end else if (free_found) begin
      waddr = free_idx;
    end else begin
      waddr = '0;
    end
  end

  assign ram_we  = (state == ST_EVAL) && is_insert;
  assign wdata   = {req.mac_addr, req.ip_addr};
  assign wr_mask = ENTRIES'(1) << waddr;

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign res       = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      cmp_vld       <= 1'b0;
      entry_valid   <= '0;
      entry_written <= '0;
      found         <= 1'b0;
      free_found    <= 1'b0;
    end else begin
      cmp_vld <= issue;
      cmp_idx <= raddr;

      // Merged match and free-slot search
      if (cmp_vld) begin
        if (!found && match) begin
          found <= 1'b1;
          fidx  <= cmp_idx;
          fmac  <= eff_mac;
        end
        if (!free_found && !entry_valid[cmp_idx]) begin
          free_found <= 1'b1;
          free_idx   <= cmp_idx;
        end
      end

      case (state)
        ST_IDLE: begin
          if (start) begin
            req        <= req_in;
            cnt        <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            res_q      <= '0;
            case (req_in.req_type)
              REQ_LOOKUP, REQ_INSERT: state <= ST_SCAN;
              REQ_FLUSH: begin
                entry_valid <= '0;
                state       <= ST_DONE;
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_SCAN: begin
          if (issue) begin
            cnt <= cnt + CNT_W'(1);
          end else begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (is_insert) begin
            entry_valid[waddr]   <= 1'b1;
            entry_written[waddr] <= 1'b1;
            res_q.hit     <= found;
            res_q.mac_out <= '0;
            res_q.slot    <= SLOT_W'(waddr);
          end else begin
            res_q.hit     <= found;
            res_q.mac_out <= found ? fmac : '0;
            res_q.slot    <= found ? SLOT_W'(fidx) : '0;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  a_we_only_insert: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_EVAL) && (req.req_type == REQ_INSERT))
    else $error("table write outside insert write-back");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (start && idle && (req_in.req_type == REQ_FLUSH)) |=> (entry_valid == '0))
    else $error("flush left a valid mark set");

  a_insert_marks: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> ((entry_valid & $past(wr_mask)) != '0) && ((entry_written & $past(wr_mask)) != '0))
    else $error("inserted entry not marked valid");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(ENTRIES))
    else $error("scan counter beyond table depth");

  a_lookup_hit_valid: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_EVAL) && (req.req_type == REQ_LOOKUP) && found) |-> entry_valid[fidx])
    else $error("lookup hit on an invalid entry");

endmodule

[design/arp_cache_table.sv]
// ARP cache table: maps IPv4 addresses to 48-bit MAC addresses.
// Request channel (s_*): tuser carries the request kind (lookup, insert or
// refresh, flush all valid marks); tdata carries the IPv4 and MAC addresses.
// Result channel (m_*): exactly one result transaction per request; tuser is
// the hit flag, tdata carries the MAC found and the slot index.
// Lookup and insert read every entry of the table memory once through its
// single registered read port (scan), then evaluate and write back, then
// present the result; flush and unused codes go straight to the result.
// One request is in work at a time; s_tready is high only while the engine
// is free. A finished result sits in the output register, so the next
// request can be accepted while the receiver holds m_tready low; a second
// result then waits in the engine until the output register drains.
// Reset (rst, synchronous) clears all valid marks and the written marks that
// make never-written entries read as zero; no clearing pass is needed.
// Flush clears the valid marks only and keeps stored addresses.
module arp_cache_table
  import arpc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // ip_addr[31:0], mac_addr[79:32]
  input  logic [REQ_W-1:0]    s_tuser,   // req_type[1:0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // mac_out[47:0], slot[51:48], zero pad
  output logic                m_tuser    // hit
);

  req_t req_in;
  res_t res;
  logic start;
  logic idle;
  logic res_valid;
  logic res_ready;
  logic load;

  assign req_in.req_type = s_tuser;
  assign req_in.ip_addr  = s_tdata[IP_W-1:0];
  assign req_in.mac_addr = s_tdata[IP_W+MAC_W-1:IP_W];

  assign s_tready = idle;
  assign start    = s_tvalid && idle;

  arpc_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req_in    (req_in),
    .idle      (idle),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register
  assign res_ready = !m_tvalid || m_tready;
  assign load      = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= M_DATA_W'({res.slot, res.mac_out});
      m_tuser <= res.hit;
    end
  end

endmodule

[tb/sv/tb_arp_cache_table.sv]
module tb_arp_cache_table;
  import arpc_pkg::*;

  // Request code the block must ignore
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int POOL_SIZE     = 20;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 30;
  localparam int MAX_REPORTS   = 10;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;   // ip_addr[31:0], mac_addr[79:32]
  logic [REQ_W-1:0]    s_tuser;   // req_type[1:0]
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;   // mac_out[47:0], slot[51:48], zero pad
  logic                m_tuser;   // hit

  // Shadow copy of the table contents
  logic             cache_valid [ENTRIES];
  logic [IP_W-1:0]  cache_ip    [ENTRIES];
  logic [MAC_W-1:0] cache_mac   [ENTRIES];

  // Results predicted for accepted requests, oldest first
  res_t pending_res[$];

  // Small address set so that lookups and refreshes hit often
  logic [IP_W-1:0] ip_pool [POOL_SIZE];

  int errors;
  bit no_idle  = 1'b0;
  bit hold_req = 1'b0;

  arp_cache_table u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Table behavior: updates the shadow copy and returns the result
  function automatic res_t predict_result(input logic [REQ_W-1:0] kind,
                                          input logic [IP_W-1:0]  ip,
                                          input logic [MAC_W-1:0] mac);
    res_t r;
    int   match_idx;
    int   free_idx;
    int   idx;
    r         = '0;
    match_idx = -1;
    free_idx  = -1;
    idx       = 0;
    case (kind)
      REQ_LOOKUP: begin
        // scan downward so the lowest matching entry wins
        for (int i = ENTRIES - 1; i >= 0; i--) begin
          if (cache_valid[i] && cache_ip[i] == ip) begin
            r.hit     = 1'b1;
            r.mac_out = cache_mac[i];
            r.slot    = SLOT_W'(i);
          end
        end
      end
      REQ_INSERT: begin
        // address match ignores the valid mark
        for (int i = ENTRIES - 1; i >= 0; i--) begin
          if (cache_ip[i] == ip) match_idx = i;
          if (!cache_valid[i]) free_idx = i;
        end
        if (match_idx >= 0) begin
          idx   = match_idx;
          r.hit = 1'b1;
        end else if (free_idx >= 0) begin
          idx = free_idx;
        end
        cache_valid[idx] = 1'b1;
        cache_ip[idx]    = ip;
        cache_mac[idx]   = mac;
        r.slot           = SLOT_W'(idx);
      end
      REQ_FLUSH: begin
        foreach (cache_valid[i]) cache_valid[i] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[MAC_W-1:0];
  endfunction

  function automatic logic [IP_W-1:0] pick_ip();
    if ($urandom_range(99) < 85) return ip_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom();
  endfunction

  function automatic void refill_pool();
    int r;
    foreach (ip_pool[i]) begin
      r = $urandom_range(9);
      ip_pool[i] = (r == 0) ? '0 : (r == 1) ? '1 : IP_W'($urandom());
    end
  endfunction

  function automatic void log_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  // Offer one request, with an optional random gap first; returns at acceptance
  task automatic send_req(input logic [REQ_W-1:0] kind,
                          input logic [IP_W-1:0]  ip,
                          input logic [MAC_W-1:0] mac);
    while (!no_idle && $urandom_range(99) < 21) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= S_DATA_W'({mac, ip});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_res.push_back(predict_result(kind, ip, mac));
  endtask

  task automatic send_random_req();
    int               p;
    logic [REQ_W-1:0] kind;
    p = $urandom_range(99);
    if (p < 45)      kind = REQ_LOOKUP;
    else if (p < 94) kind = REQ_INSERT;
    else if (p < 97) kind = REQ_FLUSH;
    else             kind = REQ_UNUSED;
    send_req(kind, pick_ip(), rand_mac());
  endtask

  // Stop offering and wait until every predicted result has been seen
  task automatic wait_for_drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
  endtask

  // Lookups, an unused code and a flush on a table that has never been written
  task automatic test_empty_table();
    send_req(REQ_LOOKUP, '0, '0);
    send_req(REQ_LOOKUP, '1, '1);
    send_req(REQ_UNUSED, '1, '1);
    send_req(REQ_FLUSH, '0, '0);
  endtask

  // Inserts, refreshes, lookups and an unused code at the field extremes
  task automatic test_insert_lookup();
    logic [IP_W-1:0]  a;
    logic [MAC_W-1:0] m;
    a = $urandom();
    m = rand_mac();
    // address 0 equals the stored address of invalid entry 0: refresh
    send_req(REQ_INSERT, '0, '1);
    send_req(REQ_INSERT, '1, '0);
    send_req(REQ_INSERT, a, m);
    send_req(REQ_LOOKUP, '0, rand_mac());
    send_req(REQ_LOOKUP, '1, rand_mac());
    send_req(REQ_LOOKUP, a, '0);
    // refresh of a valid entry with a new MAC
    send_req(REQ_INSERT, a, ~m);
    send_req(REQ_LOOKUP, a, '1);
    send_req(REQ_UNUSED, a, m);
    send_req(REQ_LOOKUP, a ^ IP_W'(1), '0);
  endtask

  // Flush keeps stored addresses; insert of one of them refreshes in place
  task automatic test_flush();
    send_req(REQ_FLUSH, $urandom(), rand_mac());
    send_req(REQ_LOOKUP, '1, '0);
    send_req(REQ_INSERT, '1, rand_mac());
    send_req(REQ_LOOKUP, '1, '0);
    send_req(REQ_LOOKUP, '0, '0);
  endtask

  // Fill every entry, then insert once more to overwrite entry 0
  task automatic test_full_table();
    logic [IP_W-1:0] fill_ip [ENTRIES];
    logic [IP_W-1:0] extra_ip;
    send_req(REQ_FLUSH, '0, '0);
    foreach (fill_ip[i]) begin
      fill_ip[i] = $urandom();
      send_req(REQ_INSERT, fill_ip[i], rand_mac());
    end
    extra_ip = $urandom();
    send_req(REQ_INSERT, extra_ip, rand_mac());
    send_req(REQ_LOOKUP, fill_ip[0], '0);
    send_req(REQ_LOOKUP, extra_ip, '0);
    send_req(REQ_LOOKUP, fill_ip[ENTRIES-1], '0);
  endtask

  // Receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (12) send_random_req();
  endtask

  // Sender goes quiet until the block has answered everything
  task automatic test_sender_pause();
    wait_for_drain();
    repeat (8) send_random_req();
  endtask

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 250 == 249) refill_pool();
      send_random_req();
    end
  endtask

  // Receiver ready pattern, with an optional long hold
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (no_idle) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 21);
      end
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    res_t exp_res;
    res_t got_res;
    if (!rst && m_tvalid && m_tready) begin
      got_res.hit     = m_tuser;
      got_res.mac_out = m_tdata[MAC_W-1:0];
      got_res.slot    = m_tdata[MAC_W+SLOT_W-1:MAC_W];
      if (pending_res.size() == 0) begin
        log_error($sformatf("result with nothing pending: hit %b mac %h slot %0d",
                            got_res.hit, got_res.mac_out, got_res.slot));
      end else begin
        exp_res = pending_res.pop_front();
        if (got_res.hit !== exp_res.hit)
          log_error($sformatf("hit: expected %b, got %b", exp_res.hit, got_res.hit));
        if (got_res.mac_out !== exp_res.mac_out)
          log_error($sformatf("mac_out: expected %h, got %h",
                              exp_res.mac_out, got_res.mac_out));
        if (got_res.slot !== exp_res.slot)
          log_error($sformatf("slot: expected %0d, got %0d", exp_res.slot, got_res.slot));
      end
    end
  end

  // Test sequence
  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = REQ_LOOKUP;
    errors   = 0;
    foreach (cache_valid[i]) begin
      cache_valid[i] = 1'b0;
      cache_ip[i]    = '0;
      cache_mac[i]   = '0;
    end
    refill_pool();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_insert_lookup();
    test_flush();
    test_full_table();
    test_random(600);
    test_backpressure();
    test_sender_pause();
    no_idle = 1'b1;
    test_random(400);
    no_idle = 1'b0;
    test_random(600);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending_res.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
